### hw/rtl/psfc_pkg.sv
// ----------------------------------------------------------------------------
// psfc_pkg
// Shared types and constants for the posture and fall classifier: field
// widths, register reset values, register indexes, event and posture codes.
// ----------------------------------------------------------------------------
package psfc_pkg;

	localparam int unsigned SampleWidth = 16;
	localparam int unsigned LimitWidth  = 15;
	localparam int unsigned EventWidth  = 3;
	localparam int unsigned CodeWidth   = 2;
	localparam int unsigned IndexWidth  = 2;
	localparam int unsigned CmpWidth    = 20;

	localparam logic [LimitWidth-1:0] PressureLimitReset = 15'd16000;
	localparam logic [LimitWidth-1:0] AccelLimitReset    = 15'd2000;
	localparam logic [LimitWidth-1:0] GyroLimitReset     = 15'd1500;
	localparam logic [LimitWidth-1:0] StillLimitReset    = 15'd10;

	typedef enum logic [IndexWidth-1:0] {
		REG_PRESSURE_LIMIT = 2'd0,
		REG_ACCEL_LIMIT    = 2'd1,
		REG_GYRO_LIMIT     = 2'd2,
		REG_STILL_LIMIT    = 2'd3
	} cfg_reg_t;

	typedef enum logic [EventWidth-1:0] {
		EV_NONE      = 3'd0,
		EV_FALL      = 3'd1,
		EV_RISE      = 3'd2,
		EV_STAND_SIT = 3'd3,
		EV_STAND_LAY = 3'd4,
		EV_SIT_LAY   = 3'd5
	} event_t;

	typedef enum logic [CodeWidth-1:0] {
		CODE_STAND = 2'd0,
		CODE_FELL  = 2'd1,
		CODE_SIT   = 2'd2,
		CODE_LAY   = 2'd3
	} posture_code_t;

	typedef enum logic [3:0] {
		ST_STAND = 4'b0001,
		ST_FELL  = 4'b0010,
		ST_SIT   = 4'b0100,
		ST_LAY   = 4'b1000
	} posture_t;

	typedef struct packed {
		logic [LimitWidth-1:0] pressure;
		logic [LimitWidth-1:0] accel;
		logic [LimitWidth-1:0] gyro;
		logic [LimitWidth-1:0] still;
	} limits_t;

	function automatic posture_code_t posture_code(input posture_t st);
		posture_code_t code;
		begin
			unique case (st)
				ST_STAND: code = CODE_STAND;
				ST_FELL:  code = CODE_FELL;
				ST_SIT:   code = CODE_SIT;
				ST_LAY:   code = CODE_LAY;
				default:  code = CODE_STAND;
			endcase
			return code;
		end
	endfunction

	function automatic logic two_of_three(input logic a, input logic b, input logic c);
		return (a & b) | (b & c) | (a & c);
	endfunction

endpackage

### hw/rtl/posture_fall_classifier_core.sv
// ----------------------------------------------------------------------------
// posture_fall_classifier_core
// Classifies body posture (stand, fell, sit, lay) from foot pressure,
// acceleration and rotation rate samples, one result word per sample word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample word (two pressures, three accel axes, three rates),
//            taken when in_valid and in_ready are both high.
//   out_*  : one result word (event_code, posture_now) per sample word,
//            taken when out_valid and out_ready are both high.
//   cfg_*  : register write port, cfg_we with cfg_index and cfg_data; write
//            only while no sample word is in flight.
// A sample word passes through one input register, then the rule logic and
// the result register. Throughput is one word per cycle while out_ready is
// high; the posture register is updated in the same cycle as the result
// register, so a back-to-back sample sees the new posture.
// When out_ready is low the result register holds and the input register
// still takes one more word; in_ready drops only when both are full.
// Reset clears both valid flags, sets posture to stand and restores the
// limit registers to their defaults.
// ----------------------------------------------------------------------------
module posture_fall_classifier_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [psfc_pkg::SampleWidth-1:0] pressure_front,
	input  logic signed [psfc_pkg::SampleWidth-1:0] pressure_back,
	input  logic signed [psfc_pkg::SampleWidth-1:0] accel_x,
	input  logic signed [psfc_pkg::SampleWidth-1:0] accel_y,
	input  logic signed [psfc_pkg::SampleWidth-1:0] accel_z,
	input  logic signed [psfc_pkg::SampleWidth-1:0] rate_x,
	input  logic signed [psfc_pkg::SampleWidth-1:0] rate_y,
	input  logic signed [psfc_pkg::SampleWidth-1:0] rate_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [psfc_pkg::EventWidth-1:0]  event_code,
	output logic        [psfc_pkg::CodeWidth-1:0]   posture_now,
	input  logic                                   cfg_we,
	input  logic        [psfc_pkg::IndexWidth-1:0]  cfg_index,
	input  logic        [psfc_pkg::LimitWidth-1:0]  cfg_data
);

	localparam int unsigned CW = psfc_pkg::CmpWidth;

	psfc_pkg::limits_t  limits_q;
	psfc_pkg::posture_t posture_q;
	psfc_pkg::posture_t posture_next;
	psfc_pkg::event_t   event_next;
	psfc_pkg::event_t   event_q;

	logic valid_s1;
	logic out_valid_q;
	logic advance;

	logic signed [psfc_pkg::SampleWidth-1:0] p1_s1, p2_s1;
	logic signed [psfc_pkg::SampleWidth-1:0] ax_s1, ay_s1, az_s1;
	logic signed [psfc_pkg::SampleWidth-1:0] gx_s1, gy_s1, gz_s1;

	logic signed [CW-1:0] p1_w, p2_w, ax_w, ay_w, az_w, gx_w, gy_w, gz_w;
	logic signed [CW-1:0] t_w, a_w, g_w, s_w;
	logic signed [CW-1:0] g4_w, gx5_w, gy5_w, gz5_w, p1x2_w, p2x2_w, p1x5_w;

	logic press_hi, acc_two, gyro_two_08, gyro_two, still, acc_low;
	logic sit_press, lay_press;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.pressure <= psfc_pkg::PressureLimitReset;
			limits_q.accel    <= psfc_pkg::AccelLimitReset;
			limits_q.gyro     <= psfc_pkg::GyroLimitReset;
			limits_q.still    <= psfc_pkg::StillLimitReset;
		end else if (cfg_we) begin
			unique case (psfc_pkg::cfg_reg_t'(cfg_index))
				psfc_pkg::REG_PRESSURE_LIMIT: limits_q.pressure <= cfg_data;
				psfc_pkg::REG_ACCEL_LIMIT:    limits_q.accel    <= cfg_data;
				psfc_pkg::REG_GYRO_LIMIT:     limits_q.gyro     <= cfg_data;
				psfc_pkg::REG_STILL_LIMIT:    limits_q.still    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			p1_s1 <= pressure_front;
			p2_s1 <= pressure_back;
			ax_s1 <= accel_x;
			ay_s1 <= accel_y;
			az_s1 <= accel_z;
			gx_s1 <= rate_x;
			gy_s1 <= rate_y;
			gz_s1 <= rate_z;
		end
	end

	// widened operands for exact scaled compares
	always_comb begin
		p1_w = CW'(p1_s1);
		p2_w = CW'(p2_s1);
		ax_w = CW'(ax_s1);
		ay_w = CW'(ay_s1);
		az_w = CW'(az_s1);
		gx_w = CW'(gx_s1);
		gy_w = CW'(gy_s1);
		gz_w = CW'(gz_s1);
		t_w  = signed'(CW'(limits_q.pressure));
		a_w  = signed'(CW'(limits_q.accel));
		g_w  = signed'(CW'(limits_q.gyro));
		s_w  = signed'(CW'(limits_q.still));

		g4_w   = g_w <<< 2;
		gx5_w  = (gx_w <<< 2) + gx_w;
		gy5_w  = (gy_w <<< 2) + gy_w;
		gz5_w  = (gz_w <<< 2) + gz_w;
		p1x2_w = p1_w <<< 1;
		p2x2_w = p2_w <<< 1;
		p1x5_w = (p1_w <<< 2) + p1_w;

		press_hi    = p1_w > t_w;
		acc_two     = psfc_pkg::two_of_three(ax_w > a_w, ay_w > a_w, az_w > a_w);
		gyro_two_08 = psfc_pkg::two_of_three(gx5_w > g4_w, gy5_w > g4_w, gz5_w > g4_w);
		gyro_two    = psfc_pkg::two_of_three(gx_w > g_w, gy_w > g_w, gz_w > g_w);
		still       = (ax_w < s_w) & (ay_w < s_w) & (az_w < s_w);
		acc_low     = (ax_w < a_w) & (ay_w < a_w) & (az_w < a_w);
		sit_press   = (p1x2_w < t_w) & (p2x2_w < t_w);
		lay_press   = p1x5_w < t_w;
	end

	// rules in priority order, each sees the posture left by the one before
	always_comb begin
		posture_next = posture_q;
		event_next   = psfc_pkg::EV_NONE;
		if (posture_next == psfc_pkg::ST_STAND &&
		    ((press_hi & acc_two) | (press_hi & gyro_two_08) | (acc_two & gyro_two))) begin
			posture_next = psfc_pkg::ST_FELL;
			event_next   = psfc_pkg::EV_FALL;
		end
		if (posture_next == psfc_pkg::ST_FELL && still && press_hi) begin
			posture_next = psfc_pkg::ST_STAND;
			event_next   = psfc_pkg::EV_RISE;
		end
		if (posture_next == psfc_pkg::ST_STAND && still && sit_press) begin
			posture_next = psfc_pkg::ST_SIT;
			event_next   = psfc_pkg::EV_STAND_SIT;
		end
		if (lay_press && gyro_two_08 && acc_low) begin
			if (posture_next == psfc_pkg::ST_STAND) begin
				posture_next = psfc_pkg::ST_LAY;
				event_next   = psfc_pkg::EV_STAND_LAY;
			end else if (posture_next == psfc_pkg::ST_SIT) begin
				posture_next = psfc_pkg::ST_LAY;
				event_next   = psfc_pkg::EV_SIT_LAY;
			end
		end
	end

	// posture state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posture_q   <= psfc_pkg::ST_STAND;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				posture_q <= posture_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q     <= event_next;
			posture_now <= psfc_pkg::posture_code(posture_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

`ifndef SYNTH
	a_lay_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		posture_q == psfc_pkg::ST_LAY |=> posture_q == psfc_pkg::ST_LAY)
		else $error("posture left lay");

	a_posture_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(posture_q))
		else $error("posture changed without a word");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> posture_now == psfc_pkg::posture_code(posture_q))
		else $error("result posture differs from state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(event_q) && $stable(posture_now))
		else $error("stalled result changed");

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(p1_s1) && $stable(gx_s1))
		else $error("input register overwritten");
`endif

endmodule
